// ===== rtl/frfs_pkg.sv =====
// ============================================================================
// frfs_pkg
// Shared types and constants for the flood relay filter and scheduler.
// ============================================================================
package frfs_pkg;

    localparam int FRFS_CACHE_DEPTH = 16;
    localparam int FRFS_ID_BITS     = 64;

    localparam int FRFS_PORT_ID_BITS = 64;
    localparam int FRFS_EVENT_BITS   = 32;
    localparam int FRFS_TYPE_BITS    = 8;
    localparam int FRFS_HOP_BITS     = 8;
    localparam int FRFS_DELAY_BITS   = 16;
    localparam int FRFS_AGE_BITS     = 20;
    localparam int FRFS_CNT_BITS     = 32;
    localparam int FRFS_ADDR_BITS    = 6;
    localparam int FRFS_DATA_BITS    = 64;

    localparam logic [FRFS_AGE_BITS-1:0] FRFS_AGE_MAX = '1;
    localparam logic [FRFS_AGE_BITS-1:0] FRFS_TTL_RESET = 20'd30000;

    // Verdict codes
    localparam logic [3:0] VERDICT_QUEUED  = 4'd0;
    localparam logic [3:0] VERDICT_OWN     = 4'd1;
    localparam logic [3:0] VERDICT_DUP     = 4'd2;
    localparam logic [3:0] VERDICT_HOPS    = 4'd3;
    localparam logic [3:0] VERDICT_TYPE    = 4'd4;
    localparam logic [3:0] VERDICT_PREP    = 4'd5;
    localparam logic [3:0] VERDICT_SEND    = 4'd6;
    localparam logic [3:0] VERDICT_EXPIRED = 4'd7;
    localparam logic [3:0] VERDICT_IDLE    = 4'd8;

    // Register indexes (byte address = 8 * index)
    localparam logic [2:0] REG_OWN_ID    = 3'd0;
    localparam logic [2:0] REG_TTL       = 3'd1;
    localparam logic [2:0] REG_TYPE_EVT  = 3'd2;
    localparam logic [2:0] REG_TYPE_ACK  = 3'd3;
    localparam logic [2:0] REG_TYPE_HB   = 3'd4;

    // Input command codes
    localparam logic CMD_FRAME = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MATCH,
        ST_DECIDE
    } frfs_state_t;

endpackage

// ===== rtl/frfs_cell.sv =====
// ============================================================================
// frfs_cell
// One entry of the seen cache: holds an (origin, event, type) entry, matches
// it against the broadcast key and passes it on to the next cell on insert.
// ============================================================================
module frfs_cell #(
    parameter int ID_BITS = frfs_pkg::FRFS_ID_BITS
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 shift_en,
    input  logic [ID_BITS-1:0]                   key_origin,
    input  logic [frfs_pkg::FRFS_EVENT_BITS-1:0] key_event,
    input  logic [frfs_pkg::FRFS_TYPE_BITS-1:0]  key_type,
    input  logic [ID_BITS-1:0]                   prev_origin,
    input  logic [frfs_pkg::FRFS_EVENT_BITS-1:0] prev_event,
    input  logic [frfs_pkg::FRFS_TYPE_BITS-1:0]  prev_type,
    input  logic                                 prev_used,
    output logic [ID_BITS-1:0]                   ent_origin,
    output logic [frfs_pkg::FRFS_EVENT_BITS-1:0] ent_event,
    output logic [frfs_pkg::FRFS_TYPE_BITS-1:0]  ent_type,
    output logic                                 ent_used,
    output logic                                 hit
);
    import frfs_pkg::*;

    logic [ID_BITS-1:0]         origin_reg;
    logic [FRFS_EVENT_BITS-1:0] event_reg;
    logic [FRFS_TYPE_BITS-1:0]  type_reg;
    logic                       used_reg;
    logic                       hit_reg;
    logic                       hit_next;

    assign hit_next = used_reg && (origin_reg == key_origin) &&
                      (event_reg == key_event) && (type_reg == key_type);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= 1'b0;
            hit_reg  <= 1'b0;
        end
        else
        begin
            hit_reg <= hit_next;
            if (shift_en)
            begin
                used_reg <= prev_used;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            origin_reg <= prev_origin;
            event_reg  <= prev_event;
            type_reg   <= prev_type;
        end
    end

    assign ent_origin = origin_reg;
    assign ent_event  = event_reg;
    assign ent_type   = type_reg;
    assign ent_used   = used_reg;
    assign hit        = hit_reg;

endmodule

// ===== rtl/flood_relay_filter_scheduler_unit.sv =====
// ============================================================================
// flood_relay_filter_scheduler_unit
// Flood relay filter with duplicate suppression and a single pending relay.
// ============================================================================
// Each input transaction (a received frame or a 1 ms tick) gives exactly one
// result transaction. An item goes through capture, compare against every
// cache cell in parallel (one registered match flag per cell), then decide
// and update, which waits while the output is stalled; the next item is
// taken once the unit is back in idle, so items never overlap. The seen
// cache is a chain of CACHE_DEPTH cells: a queued frame enters the first
// cell and every entry moves one cell along, the oldest falling off the
// end, which gives oldest-first replacement. Ids are compared on their low
// ID_BITS. The stat counter outputs always show the totals after the result
// currently presented.
module flood_relay_filter_scheduler_unit #(
    parameter int CACHE_DEPTH = frfs_pkg::FRFS_CACHE_DEPTH,
    parameter int ID_BITS     = frfs_pkg::FRFS_ID_BITS
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    // config port
    input  logic                                     psel,
    input  logic                                     penable,
    input  logic                                     pwrite,
    input  logic [frfs_pkg::FRFS_ADDR_BITS-1:0]      paddr,
    input  logic [frfs_pkg::FRFS_DATA_BITS-1:0]      pwdata,
    output logic [frfs_pkg::FRFS_DATA_BITS-1:0]      prdata,
    output logic                                     pready,
    // input channel
    input  logic                                     in_valid,
    output logic                                     in_stall,
    input  logic                                     cmd,
    input  logic [frfs_pkg::FRFS_PORT_ID_BITS-1:0]   hop_src_id,
    input  logic [frfs_pkg::FRFS_PORT_ID_BITS-1:0]   src_node_id,
    input  logic [frfs_pkg::FRFS_EVENT_BITS-1:0]     evt_num,
    input  logic [frfs_pkg::FRFS_TYPE_BITS-1:0]      kind_code,
    input  logic [frfs_pkg::FRFS_HOP_BITS-1:0]       hops_taken,
    input  logic [frfs_pkg::FRFS_HOP_BITS-1:0]       hop_limit,
    input  logic                                     prepare_ok,
    input  logic [frfs_pkg::FRFS_DELAY_BITS-1:0]     relay_delay_ms,
    // output channel
    output logic                                     out_valid,
    input  logic                                     out_stall,
    output logic [3:0]                               verdict,
    output logic                                     cancelled_pending,
    output logic [frfs_pkg::FRFS_PORT_ID_BITS-1:0]   pending_origin_out,
    output logic [frfs_pkg::FRFS_EVENT_BITS-1:0]     pending_event_out,
    output logic [frfs_pkg::FRFS_TYPE_BITS-1:0]      pending_type_out,
    output logic [frfs_pkg::FRFS_CNT_BITS-1:0]       received_total,
    output logic [frfs_pkg::FRFS_CNT_BITS-1:0]       relayed_total,
    output logic [frfs_pkg::FRFS_CNT_BITS-1:0]       dropped_total,
    output logic [frfs_pkg::FRFS_CNT_BITS-1:0]       duplicate_total,
    output logic [frfs_pkg::FRFS_CNT_BITS-1:0]       expired_total
);
    import frfs_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [FRFS_PORT_ID_BITS-1:0] own_id_reg;
    logic [FRFS_AGE_BITS-1:0]     ttl_reg;
    logic [FRFS_TYPE_BITS-1:0]    type_evt_reg;
    logic [FRFS_TYPE_BITS-1:0]    type_ack_reg;
    logic [FRFS_TYPE_BITS-1:0]    type_hb_reg;
    logic                         cfg_wr;
    logic [2:0]                   cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[5:3];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_id_reg   <= '0;
            ttl_reg      <= FRFS_TTL_RESET;
            type_evt_reg <= 8'd0;
            type_ack_reg <= 8'd1;
            type_hb_reg  <= 8'd2;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_OWN_ID:   own_id_reg   <= pwdata;
                REG_TTL:      ttl_reg      <= pwdata[FRFS_AGE_BITS-1:0];
                REG_TYPE_EVT: type_evt_reg <= pwdata[FRFS_TYPE_BITS-1:0];
                REG_TYPE_ACK: type_ack_reg <= pwdata[FRFS_TYPE_BITS-1:0];
                REG_TYPE_HB:  type_hb_reg  <= pwdata[FRFS_TYPE_BITS-1:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_OWN_ID:   prdata = own_id_reg;
            REG_TTL:      prdata = FRFS_DATA_BITS'(ttl_reg);
            REG_TYPE_EVT: prdata = FRFS_DATA_BITS'(type_evt_reg);
            REG_TYPE_ACK: prdata = FRFS_DATA_BITS'(type_ack_reg);
            REG_TYPE_HB:  prdata = FRFS_DATA_BITS'(type_hb_reg);
            default:      prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Control
    // ------------------------------------------------------------------
    frfs_state_t state_reg;
    frfs_state_t state_next;
    logic        in_accept;
    logic        out_free;
    logic        decide_go;
    logic        out_valid_reg;

    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (in_valid) state_next = ST_MATCH;
            ST_MATCH:  state_next = ST_DECIDE;
            ST_DECIDE: if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall  = 1'b1;
        decide_go = 1'b0;
        unique case (state_reg)
            ST_IDLE:   in_stall  = 1'b0;
            ST_MATCH:  ;
            ST_DECIDE: decide_go = out_free;
            default:   ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // ------------------------------------------------------------------
    // Captured item
    // ------------------------------------------------------------------
    logic                       key_cmd_reg;
    logic [ID_BITS-1:0]         key_sender_reg;
    logic [ID_BITS-1:0]         key_origin_reg;
    logic [FRFS_EVENT_BITS-1:0] key_event_reg;
    logic [FRFS_TYPE_BITS-1:0]  key_type_reg;
    logic [FRFS_HOP_BITS-1:0]   key_hops_reg;
    logic [FRFS_HOP_BITS-1:0]   key_max_reg;
    logic                       key_prep_reg;
    logic [FRFS_DELAY_BITS-1:0] key_delay_reg;

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            key_cmd_reg    <= cmd;
            key_sender_reg <= hop_src_id[ID_BITS-1:0];
            key_origin_reg <= src_node_id[ID_BITS-1:0];
            key_event_reg  <= evt_num;
            key_type_reg   <= kind_code;
            key_hops_reg   <= hops_taken;
            key_max_reg    <= hop_limit;
            key_prep_reg   <= prepare_ok;
            key_delay_reg  <= relay_delay_ms;
        end
    end

    // ------------------------------------------------------------------
    // Seen cache: chain of cells
    // ------------------------------------------------------------------
    logic [ID_BITS-1:0]         chain_origin [CACHE_DEPTH];
    logic [FRFS_EVENT_BITS-1:0] chain_event  [CACHE_DEPTH];
    logic [FRFS_TYPE_BITS-1:0]  chain_type   [CACHE_DEPTH];
    logic                       chain_used   [CACHE_DEPTH];
    logic [CACHE_DEPTH-1:0]     hit_vec;
    logic                       shift_en;

    genvar gi;
    generate
        for (gi = 0; gi < CACHE_DEPTH; gi++)
        begin : g_cell
            if (gi == 0)
            begin : g_head
                frfs_cell #(
                    .ID_BITS (ID_BITS)
                ) u_cell (
                    .clk         (clk),
                    .rst_n       (rst_n),
                    .shift_en    (shift_en),
                    .key_origin  (key_origin_reg),
                    .key_event   (key_event_reg),
                    .key_type    (key_type_reg),
                    .prev_origin (key_origin_reg),
                    .prev_event  (key_event_reg),
                    .prev_type   (key_type_reg),
                    .prev_used   (1'b1),
                    .ent_origin  (chain_origin[gi]),
                    .ent_event   (chain_event[gi]),
                    .ent_type    (chain_type[gi]),
                    .ent_used    (chain_used[gi]),
                    .hit         (hit_vec[gi])
                );
            end
            else
            begin : g_body
                frfs_cell #(
                    .ID_BITS (ID_BITS)
                ) u_cell (
                    .clk         (clk),
                    .rst_n       (rst_n),
                    .shift_en    (shift_en),
                    .key_origin  (key_origin_reg),
                    .key_event   (key_event_reg),
                    .key_type    (key_type_reg),
                    .prev_origin (chain_origin[gi-1]),
                    .prev_event  (chain_event[gi-1]),
                    .prev_type   (chain_type[gi-1]),
                    .prev_used   (chain_used[gi-1]),
                    .ent_origin  (chain_origin[gi]),
                    .ent_event   (chain_event[gi]),
                    .ent_type    (chain_type[gi]),
                    .ent_used    (chain_used[gi]),
                    .hit         (hit_vec[gi])
                );
            end
        end
    endgenerate

    // ------------------------------------------------------------------
    // Pending relay and decision
    // ------------------------------------------------------------------
    logic                       pend_valid_reg;
    logic [ID_BITS-1:0]         pend_origin_reg;
    logic [FRFS_EVENT_BITS-1:0] pend_event_reg;
    logic [FRFS_TYPE_BITS-1:0]  pend_type_reg;
    logic [FRFS_DELAY_BITS-1:0] pend_delay_reg;
    logic [FRFS_AGE_BITS-1:0]   pend_age_reg;
    logic [FRFS_AGE_BITS-1:0]   age_inc;

    logic is_frame;
    logic cache_hit;
    logic own_echo;
    logic hops_over;
    logic type_ok;
    logic pend_match;
    logic tick_expire;
    logic tick_send;
    logic frame_queued;
    logic frame_cancel;
    logic [3:0] verdict_next;

    assign is_frame  = (key_cmd_reg == CMD_FRAME);
    assign cache_hit = |hit_vec;
    assign own_echo  = (key_sender_reg == own_id_reg[ID_BITS-1:0]);
    assign hops_over = (key_hops_reg >= key_max_reg);
    assign type_ok   = (key_type_reg == type_evt_reg) || (key_type_reg == type_ack_reg) ||
                       (key_type_reg == type_hb_reg);
    assign pend_match = pend_valid_reg && (pend_origin_reg == key_origin_reg) &&
                        (pend_event_reg == key_event_reg) && (pend_type_reg == key_type_reg);

    assign age_inc = (pend_age_reg == FRFS_AGE_MAX) ? pend_age_reg : pend_age_reg + 1'b1;
    assign tick_expire = pend_valid_reg && (age_inc > ttl_reg);
    assign tick_send   = pend_valid_reg && !tick_expire &&
                         (age_inc >= FRFS_AGE_BITS'(pend_delay_reg));

    always_comb
    begin
        frame_queued = 1'b0;
        frame_cancel = 1'b0;
        priority if (!is_frame)
        begin
            if (tick_expire)
                verdict_next = VERDICT_EXPIRED;
            else if (tick_send)
                verdict_next = VERDICT_SEND;
            else
                verdict_next = VERDICT_IDLE;
        end
        else if (own_echo)
        begin
            verdict_next = VERDICT_OWN;
        end
        else if (cache_hit)
        begin
            verdict_next = VERDICT_DUP;
            frame_cancel = pend_match;
        end
        else if (hops_over)
        begin
            verdict_next = VERDICT_HOPS;
        end
        else if (!type_ok)
        begin
            verdict_next = VERDICT_TYPE;
        end
        else if (!key_prep_reg)
        begin
            verdict_next = VERDICT_PREP;
        end
        else
        begin
            verdict_next = VERDICT_QUEUED;
            frame_queued = 1'b1;
        end
    end

    assign shift_en = decide_go && frame_queued;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
        end
        else if (decide_go)
        begin
            if (frame_queued)
                pend_valid_reg <= 1'b1;
            else if (frame_cancel || (!is_frame && (tick_expire || tick_send)))
                pend_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            pend_origin_reg <= key_origin_reg;
            pend_event_reg  <= key_event_reg;
            pend_type_reg   <= key_type_reg;
            pend_delay_reg  <= key_delay_reg;
            pend_age_reg    <= '0;
        end
        else if (decide_go && !is_frame && pend_valid_reg)
        begin
            pend_age_reg <= age_inc;
        end
    end

    // ------------------------------------------------------------------
    // Counters; they move only when a result is loaded, so they always
    // match the result on show.
    // ------------------------------------------------------------------
    logic [FRFS_CNT_BITS-1:0] cnt_rx_reg;
    logic [FRFS_CNT_BITS-1:0] cnt_relayed_reg;
    logic [FRFS_CNT_BITS-1:0] cnt_dropped_reg;
    logic [FRFS_CNT_BITS-1:0] cnt_dup_reg;
    logic [FRFS_CNT_BITS-1:0] cnt_expired_reg;
    logic                     tick_item;

    assign tick_item = !is_frame;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_rx_reg      <= '0;
            cnt_relayed_reg <= '0;
            cnt_dropped_reg <= '0;
            cnt_dup_reg     <= '0;
            cnt_expired_reg <= '0;
        end
        else if (decide_go)
        begin
            if (is_frame)
                cnt_rx_reg <= cnt_rx_reg + 1'b1;
            if ((is_frame && !frame_queued) || (tick_item && tick_expire))
                cnt_dropped_reg <= cnt_dropped_reg + 1'b1;
            if (is_frame && !own_echo && cache_hit)
                cnt_dup_reg <= cnt_dup_reg + 1'b1;
            if (tick_item && tick_send)
                cnt_relayed_reg <= cnt_relayed_reg + 1'b1;
            if (tick_item && tick_expire)
                cnt_expired_reg <= cnt_expired_reg + 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic [3:0]                   verdict_reg;
    logic                         cancel_reg;
    logic [FRFS_PORT_ID_BITS-1:0] out_origin_reg;
    logic [FRFS_EVENT_BITS-1:0]   out_event_reg;
    logic [FRFS_TYPE_BITS-1:0]    out_type_reg;
    logic                         show_pend;

    assign show_pend = tick_item && (tick_expire || tick_send);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (decide_go)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (decide_go)
        begin
            verdict_reg    <= verdict_next;
            cancel_reg     <= frame_cancel;
            out_origin_reg <= show_pend ? FRFS_PORT_ID_BITS'(pend_origin_reg) : '0;
            out_event_reg  <= show_pend ? pend_event_reg : '0;
            out_type_reg   <= show_pend ? pend_type_reg : '0;
        end
    end

    assign out_valid          = out_valid_reg;
    assign verdict            = verdict_reg;
    assign cancelled_pending  = cancel_reg;
    assign pending_origin_out = out_origin_reg;
    assign pending_event_out  = out_event_reg;
    assign pending_type_out   = out_type_reg;
    assign received_total     = cnt_rx_reg;
    assign relayed_total      = cnt_relayed_reg;
    assign dropped_total      = cnt_dropped_reg;
    assign duplicate_total    = cnt_dup_reg;
    assign expired_total      = cnt_expired_reg;

endmodule

// ===== rtl/frfs_checker.sv =====
// ============================================================================
// frfs_checker
// Port-level checks on the result channel of the relay filter.
// ============================================================================
module frfs_checker (
    input logic                                   clk,
    input logic                                   rst_n,
    input logic                                   out_valid,
    input logic                                   out_stall,
    input logic [3:0]                             verdict,
    input logic                                   cancelled_pending,
    input logic [frfs_pkg::FRFS_PORT_ID_BITS-1:0] pending_origin_out,
    input logic [frfs_pkg::FRFS_EVENT_BITS-1:0]   pending_event_out,
    input logic [frfs_pkg::FRFS_TYPE_BITS-1:0]    pending_type_out,
    input logic [frfs_pkg::FRFS_CNT_BITS-1:0]     relayed_total,
    input logic [frfs_pkg::FRFS_CNT_BITS-1:0]     expired_total
);
    import frfs_pkg::*;

    // a cancel only comes with a duplicate
    a_cancel_dup: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && cancelled_pending |-> verdict == VERDICT_DUP)
        else $error("cancel flagged on a non-duplicate verdict");

    // relay fields are shown only for transmit or expiry
    a_pend_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && verdict != VERDICT_SEND && verdict != VERDICT_EXPIRED |->
        pending_origin_out == '0 && pending_event_out == '0 && pending_type_out == '0)
        else $error("relay fields set on a verdict that carries none");

    // a new transmit result carries a bumped relay count
    a_send_count: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) && verdict == VERDICT_SEND |->
        relayed_total != $past(relayed_total))
        else $error("transmit without relay count moving");

    // a held result keeps its verdict and expiry total
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=>
        out_valid && $stable(verdict) && $stable(expired_total))
        else $error("stalled transaction changed");

endmodule

bind flood_relay_filter_scheduler_unit frfs_checker u_frfs_checker (.*);

// ===== tb/frfs_checker.sv =====
// ============================================================================
// frfs_scoreboard
// Watches the config port and both channels of the flood relay filter,
// predicts one result per accepted input transaction and compares each
// accepted output transaction field by field against the oldest prediction.
// ============================================================================
module frfs_scoreboard (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     psel,
    input  logic                                     penable,
    input  logic                                     pwrite,
    input  logic                                     pready,
    input  logic [frfs_pkg::FRFS_ADDR_BITS-1:0]      paddr,
    input  logic [frfs_pkg::FRFS_DATA_BITS-1:0]      pwdata,
    input  logic                                     in_valid,
    input  logic                                     in_stall,
    input  logic                                     cmd,
    input  logic [frfs_pkg::FRFS_PORT_ID_BITS-1:0]   hop_src_id,
    input  logic [frfs_pkg::FRFS_PORT_ID_BITS-1:0]   src_node_id,
    input  logic [frfs_pkg::FRFS_EVENT_BITS-1:0]     evt_num,
    input  logic [frfs_pkg::FRFS_TYPE_BITS-1:0]      kind_code,
    input  logic [frfs_pkg::FRFS_HOP_BITS-1:0]       hops_taken,
    input  logic [frfs_pkg::FRFS_HOP_BITS-1:0]       hop_limit,
    input  logic                                     prepare_ok,
    input  logic [frfs_pkg::FRFS_DELAY_BITS-1:0]     relay_delay_ms,
    input  logic                                     out_valid,
    input  logic                                     out_stall,
    input  logic [3:0]                               verdict,
    input  logic                                     cancelled_pending,
    input  logic [frfs_pkg::FRFS_PORT_ID_BITS-1:0]   pending_origin_out,
    input  logic [frfs_pkg::FRFS_EVENT_BITS-1:0]     pending_event_out,
    input  logic [frfs_pkg::FRFS_TYPE_BITS-1:0]      pending_type_out,
    input  logic [frfs_pkg::FRFS_CNT_BITS-1:0]       received_total,
    input  logic [frfs_pkg::FRFS_CNT_BITS-1:0]       relayed_total,
    input  logic [frfs_pkg::FRFS_CNT_BITS-1:0]       dropped_total,
    input  logic [frfs_pkg::FRFS_CNT_BITS-1:0]       duplicate_total,
    input  logic [frfs_pkg::FRFS_CNT_BITS-1:0]       expired_total,
    output int                                       errors,
    output int                                       outstanding
);
    timeunit 1ns;
    timeprecision 1ps;
    import frfs_pkg::*;

    localparam logic [63:0] ID_MASK = {64{1'b1}} >> (64 - FRFS_ID_BITS);
    localparam int PTR_BITS = $clog2(FRFS_CACHE_DEPTH);

    typedef struct packed {
        logic [3:0]  verdict;
        logic        cancelled;
        logic [63:0] origin;
        logic [31:0] evt;
        logic [7:0]  typ;
        logic [31:0] rx;
        logic [31:0] relayed;
        logic [31:0] dropped;
        logic [31:0] dup;
        logic [31:0] expired;
    } relay_result_t;

    // configuration as seen on the bus
    logic [63:0] own_id;
    logic [19:0] ttl_ms;
    logic [7:0]  code_evt;
    logic [7:0]  code_ack;
    logic [7:0]  code_hb;

    // seen cache and the single pending relay
    logic [63:0] seen_org  [FRFS_CACHE_DEPTH];
    logic [31:0] seen_evt  [FRFS_CACHE_DEPTH];
    logic [7:0]  seen_typ  [FRFS_CACHE_DEPTH];
    logic        seen_used [FRFS_CACHE_DEPTH];
    logic [PTR_BITS-1:0] ring_ptr;
    logic        pend_valid;
    logic [63:0] pend_org;
    logic [31:0] pend_evt;
    logic [7:0]  pend_typ;
    logic [15:0] pend_delay;
    logic [19:0] pend_age;
    logic [31:0] cnt_rx, cnt_relayed, cnt_dropped, cnt_dup, cnt_expired;

    relay_result_t due_results [$];

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("%0t mismatch: %s got %h want %h", $realtime, what, got, want);
        errors = errors + 1;
    endtask

    task automatic check_field(input string what, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            report(what, got, want);
    endtask

    task automatic filter_frame(output relay_result_t r);
        logic [63:0] snd;
        logic [63:0] org;
        logic        hit;
        r = '0;
        snd = hop_src_id & ID_MASK;
        org = src_node_id & ID_MASK;
        hit = 1'b0;
        for (int k = 0; k < FRFS_CACHE_DEPTH; k++)
            if (seen_used[k] && seen_org[k] == org && seen_evt[k] == evt_num &&
                seen_typ[k] == kind_code)
                hit = 1'b1;
        cnt_rx = cnt_rx + 1;
        if (snd == (own_id & ID_MASK)) begin
            cnt_dropped = cnt_dropped + 1;
            r.verdict = VERDICT_OWN;
        end else if (hit) begin
            cnt_dup = cnt_dup + 1;
            cnt_dropped = cnt_dropped + 1;
            r.verdict = VERDICT_DUP;
            if (pend_valid && pend_org == org && pend_evt == evt_num &&
                pend_typ == kind_code) begin
                pend_valid = 1'b0;
                r.cancelled = 1'b1;
            end
        end else if (hops_taken >= hop_limit) begin
            cnt_dropped = cnt_dropped + 1;
            r.verdict = VERDICT_HOPS;
        end else if (kind_code != code_evt && kind_code != code_ack &&
                     kind_code != code_hb) begin
            cnt_dropped = cnt_dropped + 1;
            r.verdict = VERDICT_TYPE;
        end else if (!prepare_ok) begin
            cnt_dropped = cnt_dropped + 1;
            r.verdict = VERDICT_PREP;
        end else begin
            seen_org[ring_ptr]  = org;
            seen_evt[ring_ptr]  = evt_num;
            seen_typ[ring_ptr]  = kind_code;
            seen_used[ring_ptr] = 1'b1;
            if (int'(ring_ptr) == FRFS_CACHE_DEPTH - 1)
                ring_ptr = '0;
            else
                ring_ptr = ring_ptr + 1'b1;
            // a new relay simply overwrites the old one
            pend_valid = 1'b1;
            pend_org   = org;
            pend_evt   = evt_num;
            pend_typ   = kind_code;
            pend_delay = relay_delay_ms;
            pend_age   = '0;
            r.verdict  = VERDICT_QUEUED;
        end
    endtask

    task automatic age_relay(output relay_result_t r);
        r = '0;
        r.verdict = VERDICT_IDLE;
        if (pend_valid) begin
            if (pend_age != FRFS_AGE_MAX)
                pend_age = pend_age + 20'd1;
            // expiry takes precedence over firing
            if (pend_age > ttl_ms) begin
                cnt_expired = cnt_expired + 1;
                cnt_dropped = cnt_dropped + 1;
                r.verdict = VERDICT_EXPIRED;
            end else if (pend_age >= {4'd0, pend_delay}) begin
                cnt_relayed = cnt_relayed + 1;
                r.verdict = VERDICT_SEND;
            end
            if (r.verdict != VERDICT_IDLE) begin
                pend_valid = 1'b0;
                r.origin = pend_org;
                r.evt    = pend_evt;
                r.typ    = pend_typ;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n) begin : monitor
        relay_result_t got;
        relay_result_t want;
        if (!rst_n) begin
            own_id   = '0;
            ttl_ms   = FRFS_TTL_RESET;
            code_evt = 8'd0;
            code_ack = 8'd1;
            code_hb  = 8'd2;
            for (int k = 0; k < FRFS_CACHE_DEPTH; k++) begin
                seen_org[k]  = '0;
                seen_evt[k]  = '0;
                seen_typ[k]  = '0;
                seen_used[k] = 1'b0;
            end
            ring_ptr    = '0;
            pend_valid  = 1'b0;
            pend_org    = '0;
            pend_evt    = '0;
            pend_typ    = '0;
            pend_delay  = '0;
            pend_age    = '0;
            cnt_rx      = '0;
            cnt_relayed = '0;
            cnt_dropped = '0;
            cnt_dup     = '0;
            cnt_expired = '0;
            due_results.delete();
            errors      = 0;
            outstanding = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[5:3])
                    REG_OWN_ID:   own_id   = pwdata;
                    REG_TTL:      ttl_ms   = pwdata[19:0];
                    REG_TYPE_EVT: code_evt = pwdata[7:0];
                    REG_TYPE_ACK: code_ack = pwdata[7:0];
                    REG_TYPE_HB:  code_hb  = pwdata[7:0];
                    default: ;
                endcase
            end
            if (out_valid && !out_stall) begin
                got.verdict   = verdict;
                got.cancelled = cancelled_pending;
                got.origin    = pending_origin_out;
                got.evt       = pending_event_out;
                got.typ       = pending_type_out;
                got.rx        = received_total;
                got.relayed   = relayed_total;
                got.dropped   = dropped_total;
                got.dup       = duplicate_total;
                got.expired   = expired_total;
                if (due_results.size() == 0) begin
                    report("result transaction with nothing due", {60'd0, verdict}, '0);
                end else begin
                    want = due_results.pop_front();
                    check_field("verdict", 64'(got.verdict), 64'(want.verdict));
                    check_field("cancelled_pending", 64'(got.cancelled),
                                64'(want.cancelled));
                    check_field("pending_origin_out", got.origin, want.origin);
                    check_field("pending_event_out", 64'(got.evt), 64'(want.evt));
                    check_field("pending_type_out", 64'(got.typ), 64'(want.typ));
                    check_field("received_total", 64'(got.rx), 64'(want.rx));
                    check_field("relayed_total", 64'(got.relayed), 64'(want.relayed));
                    check_field("dropped_total", 64'(got.dropped), 64'(want.dropped));
                    check_field("duplicate_total", 64'(got.dup), 64'(want.dup));
                    check_field("expired_total", 64'(got.expired), 64'(want.expired));
                end
            end
            if (in_valid && !in_stall) begin
                if (cmd == CMD_FRAME)
                    filter_frame(want);
                else
                    age_relay(want);
                want.rx      = cnt_rx;
                want.relayed = cnt_relayed;
                want.dropped = cnt_dropped;
                want.dup     = cnt_dup;
                want.expired = cnt_expired;
                due_results.push_back(want);
            end
            outstanding = due_results.size();
        end
    end

endmodule

// ===== tb/tb_flood_relay_filter_scheduler_unit.sv =====
// ============================================================================
// tb_flood_relay_filter_scheduler_unit
// Drives frames and ticks into the flood relay filter under several register
// settings, with random idling on both channels; the scoreboard does the
// prediction and comparison, and this module gives the final verdict.
// ============================================================================
module tb_flood_relay_filter_scheduler_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import frfs_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_OFF_CYCLES = 150;
    localparam int PHASE_ITEMS = 290;

    typedef struct {
        logic        cmd;
        logic [63:0] snd;
        logic [63:0] org;
        logic [31:0] evt;
        logic [7:0]  typ;
        logic [7:0]  hops;
        logic [7:0]  maxh;
        logic        prep;
        logic [15:0] dly;
    } frame_item_t;

    logic                          clk;
    logic                          rst_n;
    logic                          psel, penable, pwrite;
    logic [FRFS_ADDR_BITS-1:0]     paddr;
    logic [FRFS_DATA_BITS-1:0]     pwdata;
    logic [FRFS_DATA_BITS-1:0]     prdata;
    logic                          pready;
    logic                          in_valid, in_stall;
    logic                          cmd;
    logic [FRFS_PORT_ID_BITS-1:0]  hop_src_id, src_node_id;
    logic [FRFS_EVENT_BITS-1:0]    evt_num;
    logic [FRFS_TYPE_BITS-1:0]     kind_code;
    logic [FRFS_HOP_BITS-1:0]      hops_taken, hop_limit;
    logic                          prepare_ok;
    logic [FRFS_DELAY_BITS-1:0]    relay_delay_ms;
    logic                          out_valid, out_stall;
    logic [3:0]                    verdict;
    logic                          cancelled_pending;
    logic [FRFS_PORT_ID_BITS-1:0]  pending_origin_out;
    logic [FRFS_EVENT_BITS-1:0]    pending_event_out;
    logic [FRFS_TYPE_BITS-1:0]     pending_type_out;
    logic [FRFS_CNT_BITS-1:0]      received_total, relayed_total, dropped_total;
    logic [FRFS_CNT_BITS-1:0]      duplicate_total, expired_total;
    int                            errors;
    int                            outstanding;

    // generator view of the current settings
    logic [63:0] cur_own;
    logic [7:0]  cur_evt, cur_ack, cur_hb;
    logic [63:0] origin_pool [4];
    logic [63:0] last_org;
    logic [31:0] last_evt;
    logic [7:0]  last_typ;
    bit          quiet;
    bit          hold_req;
    int          idle_cycles;

    flood_relay_filter_scheduler_unit uut (.*);
    frfs_scoreboard u_scoreboard (.*);

    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // result side: random stall before each transaction, one long hold-off on request
    initial begin : receiver
        int unsigned w;
        bit          hold_done;
        hold_done = 1'b0;
        out_stall = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            w = quiet ? 0 : $urandom_range(0, 6);
            if (hold_req && !hold_done) begin
                w = HOLD_OFF_CYCLES;
                hold_done = 1'b1;
            end
            @(negedge clk);
            if (w != 0) begin
                out_stall <= 1'b1;
                repeat (w) @(negedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    task automatic apb_write(input logic [2:0] idx, input logic [63:0] val);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_config(input logic [63:0] own, input logic [19:0] ttl,
                              input logic [7:0] c_evt, input logic [7:0] c_ack,
                              input logic [7:0] c_hb);
        apb_write(REG_OWN_ID, own);
        apb_write(REG_TTL, {44'd0, ttl});
        apb_write(REG_TYPE_EVT, {56'd0, c_evt});
        apb_write(REG_TYPE_ACK, {56'd0, c_ack});
        apb_write(REG_TYPE_HB, {56'd0, c_hb});
        cur_own = own;
        cur_evt = c_evt;
        cur_ack = c_ack;
        cur_hb  = c_hb;
    endtask

    // drop valid and wait for every due result, then let the unit settle
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        wait (outstanding == 0);
        repeat (6) @(negedge clk);
    endtask

    task automatic offer(input frame_item_t it);
        int unsigned gap;
        gap = quiet ? 0 : $urandom_range(0, 6);
        @(negedge clk);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd            <= it.cmd;
        hop_src_id     <= it.snd;
        src_node_id    <= it.org;
        evt_num        <= it.evt;
        kind_code      <= it.typ;
        hops_taken     <= it.hops;
        hop_limit      <= it.maxh;
        prepare_ok     <= it.prep;
        relay_delay_ms <= it.dly;
        in_valid       <= 1'b1;
        do @(posedge clk); while (in_stall);
    endtask

    function automatic frame_item_t mk_frame(input logic [63:0] snd, input logic [63:0] org,
                                             input logic [31:0] evt, input logic [7:0] typ,
                                             input logic [7:0] hops, input logic [7:0] maxh,
                                             input logic prep, input logic [15:0] dly);
        frame_item_t it;
        it.cmd  = CMD_FRAME;
        it.snd  = snd;
        it.org  = org;
        it.evt  = evt;
        it.typ  = typ;
        it.hops = hops;
        it.maxh = maxh;
        it.prep = prep;
        it.dly  = dly;
        return it;
    endfunction

    // tick with junk in the frame fields
    function automatic frame_item_t mk_tick();
        frame_item_t it;
        it = mk_frame({$urandom, $urandom}, {$urandom, $urandom}, $urandom,
                      8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                      16'($urandom_range(0, 65535)));
        it.cmd = CMD_TICK;
        return it;
    endfunction

    // mostly well-formed frames on a small set of origins so that duplicates,
    // cancels and relays are common; the rest is noise
    function automatic frame_item_t rand_item();
        frame_item_t it;
        int unsigned r;
        it = mk_tick();
        it.cmd = ($urandom_range(0, 99) < 45) ? CMD_TICK : CMD_FRAME;
        if ($urandom_range(0, 11) == 0)
            it.snd = cur_own;
        if ($urandom_range(0, 9) == 0) begin
            it.org = last_org;
            it.evt = last_evt;
            it.typ = last_typ;
        end else begin
            if ($urandom_range(0, 3) != 0)
                it.org = origin_pool[2'($urandom_range(0, 3))];
            if ($urandom_range(0, 3) != 0)
                it.evt = $urandom_range(0, 7);
            r = $urandom_range(0, 19);
            if (r < 6)
                it.typ = cur_evt;
            else if (r < 12)
                it.typ = cur_ack;
            else if (r < 17)
                it.typ = cur_hb;
        end
        if ($urandom_range(0, 9) == 0) begin
            it.maxh = 8'($urandom_range(0, 255));
            it.hops = 8'($urandom_range(it.maxh, 255));
        end else begin
            it.hops = 8'($urandom_range(0, 254));
            it.maxh = 8'($urandom_range(it.hops + 1, 255));
        end
        it.prep = ($urandom_range(0, 9) != 0);
        if ($urandom_range(0, 19) != 0)
            it.dly = 16'($urandom_range(0, 12));
        if (it.cmd == CMD_FRAME) begin
            last_org = it.org;
            last_evt = it.evt;
            last_typ = it.typ;
        end
        return it;
    endfunction

    initial begin : stimulus
        logic [7:0] c;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_valid = 1'b0;
        cmd = CMD_FRAME;
        hop_src_id = '0;
        src_node_id = '0;
        evt_num = '0;
        kind_code = '0;
        hops_taken = '0;
        hop_limit = '0;
        prepare_ok = 1'b0;
        relay_delay_ms = '0;
        quiet = 1'b0;
        hold_req = 1'b0;
        last_org = '0;
        last_evt = '0;
        last_typ = '0;
        cur_own = '0;
        cur_evt = 8'd0;
        cur_ack = 8'd1;
        cur_hb = 8'd2;
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // settings after reset: own id 0, codes 0/1/2
        offer(mk_tick());
        offer(mk_frame('0, '1, '1, 8'd0, 8'd0, 8'd255, 1'b1, 16'hFFFF));
        offer(mk_frame('1, '1, '1, 8'd0, 8'd0, 8'd255, 1'b1, 16'hFFFF));
        offer(mk_frame('1, '1, '1, 8'd0, 8'd0, 8'd255, 1'b1, 16'd0));
        offer(mk_tick());
        offer(mk_frame(64'd1, 64'd1, 32'd1, 8'd1, 8'd255, 8'd255, 1'b1, 16'd0));
        offer(mk_frame(64'd1, 64'd1, 32'd1, 8'd1, 8'd0, 8'd0, 1'b1, 16'd0));
        offer(mk_frame(64'd1, 64'd1, 32'd1, 8'hFF, 8'd0, 8'd1, 1'b1, 16'd0));
        offer(mk_frame(64'd1, 64'd2, 32'd2, 8'd2, 8'd0, 8'd1, 1'b0, 16'd0));
        offer(mk_frame(64'd1, 64'd3, 32'd3, 8'd2, 8'd0, 8'd1, 1'b1, 16'd0));
        offer(mk_tick());
        offer(mk_frame(64'd1, 64'd3, 32'd3, 8'd2, 8'd0, 8'd1, 1'b1, 16'd0));
        offer(mk_frame(64'd1, 64'd4, 32'd4, 8'd1, 8'd3, 8'd9, 1'b1, 16'd3));
        offer(mk_frame(64'd1, 64'd5, 32'd5, 8'd0, 8'd3, 8'd9, 1'b1, 16'd2));
        offer(mk_tick());
        offer(mk_tick());
        // the failed preparation earlier must not have entered the cache
        offer(mk_frame(64'd1, 64'd2, 32'd2, 8'd2, 8'd0, 8'd1, 1'b1, 16'd1));
        offer(mk_tick());
        drain();

        set_config(64'h0123_4567_89AB_CDEF, 20'd0, 8'h10, 8'h20, 8'hFE);
        offer(mk_frame(64'h0123_4567_89AB_CDEF, 64'd6, 32'd6, 8'h10, 8'd0, 8'd1, 1'b1, 16'd0));
        offer(mk_frame(64'd1, 64'd6, 32'd6, 8'h10, 8'd0, 8'd1, 1'b1, 16'd5));
        offer(mk_tick());
        // zero delay still loses to expiry
        offer(mk_frame(64'd1, 64'd7, 32'd7, 8'h20, 8'd0, 8'd1, 1'b1, 16'd0));
        offer(mk_tick());
        drain();

        set_config(64'h0123_4567_89AB_CDEF, 20'd3, 8'h10, 8'h20, 8'hFE);
        offer(mk_frame(64'd1, 64'd8, 32'd8, 8'hFE, 8'd0, 8'd1, 1'b1, 16'd3));
        offer(mk_tick());
        offer(mk_tick());
        offer(mk_tick());

        for (int p = 0; p < 6; p++) begin
            drain();
            c = 8'($urandom_range(0, 255));
            case (p)
                0: set_config('1, 20'hFFFFF, 8'hFF, 8'h00, 8'h80);
                1: set_config({$urandom, $urandom}, 20'd0, 8'($urandom_range(0, 255)),
                              8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
                2: set_config({$urandom, $urandom}, 20'd8, 8'($urandom_range(0, 255)),
                              8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
                3: set_config({$urandom, $urandom}, 20'd30000, c, c, c);
                4: set_config('0, 20'($urandom_range(0, 20)), 8'($urandom_range(0, 255)),
                              8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
                default: set_config({$urandom, $urandom}, 20'($urandom_range(1, 15)),
                                    8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                    8'($urandom_range(0, 255)));
            endcase
            for (int k = 0; k < 4; k++)
                origin_pool[k] = {$urandom, $urandom};
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (i % 64 == 0)
                    quiet = ($urandom_range(0, 4) == 0);
                if (p == 2 && i == 40)
                    hold_req = 1'b1;
                if (p == 3 && i == 150)
                    drain();
                offer(rand_item());
            end
        end

        drain();
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
